// ----- rtl/indexed_min_heap_top_assert.svh -----
// Assertion macros for the indexed min-heap
`ifndef INDEXED_MIN_HEAP_TOP_ASSERT_SVH
`define INDEXED_MIN_HEAP_TOP_ASSERT_SVH

// checked through reset
`define IHP_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("ihp assertion failed");

// checked outside reset
`define IHP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ihp assertion failed");

`endif

// ----- rtl/ihp_pkg.sv -----
`timescale 1ns / 1ps
package ihp_pkg;

   localparam int KEY_W     = 10;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 11;
   localparam int KEY_SPACE = 1024;
   localparam int SLOT_W    = VALUE_W + KEY_W;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_FULL    = 2'd1,
      ERR_PRESENT = 2'd2,
      ERR_ABSENT  = 2'd3
   } err_type;

   typedef enum logic {
      MODE_PUSH   = 1'b0,
      MODE_MODIFY = 1'b1
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_OLD,
      ST_UP,
      ST_UP_CMP,
      ST_DOWN,
      ST_DN_L,
      ST_DN_R,
      ST_FINAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      mode_type          mode;
      logic [KEY_W-1:0]  key;
      logic [VALUE_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] min_value;
      logic [KEY_W-1:0]   min_key;
      logic [COUNT_W-1:0] entry_count;
      logic               has_entries;
      err_type            error;
   } result_type;

endpackage

// ----- rtl/ihp_ram.sv -----
`timescale 1ns / 1ps
module ihp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ihp_front.sv -----
`timescale 1ns / 1ps
module ihp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ihp_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_pop,
   output ihp_pkg::item_type out_item
);

   ihp_pkg::item_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- rtl/ihp_back.sv -----
`timescale 1ns / 1ps
module ihp_back #(
   parameter int CAPACITY = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  ihp_pkg::item_type   item,
   output logic                item_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ihp_pkg::result_type rsp
);

   localparam int SW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int KAW = $clog2(ihp_pkg::KEY_SPACE);
   localparam int VW = ihp_pkg::VALUE_W;
   localparam int KW = ihp_pkg::KEY_W;

   ihp_pkg::state_type state_ff, state_in;
   logic [KAW-1:0]      clr_ff, clr_in;
   logic [SW-1:0]       size_ff, size_in;
   logic [SW-1:0]       s_ff, s_in;
   logic [VW-1:0]       cv_ff, cv_in;
   logic [KW-1:0]       ck_ff, ck_in;
   ihp_pkg::mode_type   mode_ff, mode_in;
   ihp_pkg::err_type    err_ff, err_in;
   logic [VW-1:0]       cand_val_ff, cand_val_in;
   logic [KW-1:0]       cand_key_ff, cand_key_in;
   logic                cand_move_ff, cand_move_in;
   logic [VW-1:0]       root_val_ff, root_val_in;
   logic [KW-1:0]       root_key_ff, root_key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ihp_pkg::result_type rsp_ff, rsp_in;

   logic                       slot_wr_en;
   logic [AW-1:0]              slot_wr_addr, slot_rd_addr;
   logic [ihp_pkg::SLOT_W-1:0] slot_wr_data, slot_rd_data;
   logic                       kp_wr_en;
   logic [KAW-1:0]             kp_wr_addr, kp_rd_addr;
   logic [SW-1:0]              kp_wr_data, kp_rd_data;

   logic [VW-1:0]    rd_val;
   logic [KW-1:0]    rd_key;
   logic [SW:0]      left, right;
   logic             left_ok, right_ok, at_root, child_less, right_less, rsp_free;
   logic             up_less;
   logic [SW-1:0]    parent;
   ihp_pkg::err_type look_err;

   ihp_ram #(.WIDTH(ihp_pkg::SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_wr_en),
      .wr_addr(slot_wr_addr),
      .wr_data(slot_wr_data),
      .rd_addr(slot_rd_addr),
      .rd_data(slot_rd_data)
   );

   ihp_ram #(.WIDTH(SW), .DEPTH(ihp_pkg::KEY_SPACE)) u_pos_ram (
      .clock  (clock),
      .wr_en  (kp_wr_en),
      .wr_addr(kp_wr_addr),
      .wr_data(kp_wr_data),
      .rd_addr(kp_rd_addr),
      .rd_data(kp_rd_data)
   );

   // slot entry: key above value
   assign rd_val     = slot_rd_data[VW-1:0];
   assign rd_key     = slot_rd_data[ihp_pkg::SLOT_W-1:VW];
   assign left       = {s_ff, 1'b0};
   assign right      = {s_ff, 1'b1};
   assign left_ok    = left <= {1'b0, size_ff};
   assign right_ok   = right <= {1'b0, size_ff};
   assign parent     = s_ff >> 1;
   assign at_root    = (s_ff == SW'(1));
   assign child_less = $signed(rd_val) < $signed(cv_ff);
   assign up_less    = $signed(cv_ff) < $signed(rd_val);
   assign right_less = $signed(rd_val) < $signed(cand_val_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (mode_ff == ihp_pkg::MODE_PUSH) begin
         if (size_ff >= SW'(CAPACITY)) begin
            look_err = ihp_pkg::ERR_FULL;
         end else if (kp_rd_data != '0) begin
            look_err = ihp_pkg::ERR_PRESENT;
         end else begin
            look_err = ihp_pkg::ERR_NONE;
         end
      end else begin
         if (kp_rd_data == '0 || kp_rd_data > size_ff) begin
            look_err = ihp_pkg::ERR_ABSENT;
         end else begin
            look_err = ihp_pkg::ERR_NONE;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ihp_pkg::ST_CLEAR: begin
            if (clr_ff == KAW'(ihp_pkg::KEY_SPACE - 1)) state_in = ihp_pkg::ST_IDLE;
         end
         ihp_pkg::ST_IDLE: begin
            if (item_valid) state_in = ihp_pkg::ST_LOOK;
         end
         ihp_pkg::ST_LOOK: begin
            if (look_err != ihp_pkg::ERR_NONE) begin
               state_in = ihp_pkg::ST_DONE;
            end else if (mode_ff == ihp_pkg::MODE_PUSH) begin
               state_in = ihp_pkg::ST_UP;
            end else begin
               state_in = ihp_pkg::ST_OLD;
            end
         end
         ihp_pkg::ST_OLD: begin
            state_in = ($signed(cv_ff) > $signed(rd_val)) ? ihp_pkg::ST_DOWN : ihp_pkg::ST_UP;
         end
         ihp_pkg::ST_UP: begin
            state_in = at_root ? ihp_pkg::ST_FINAL : ihp_pkg::ST_UP_CMP;
         end
         ihp_pkg::ST_UP_CMP: begin
            state_in = up_less ? ihp_pkg::ST_UP : ihp_pkg::ST_FINAL;
         end
         ihp_pkg::ST_DOWN: begin
            state_in = left_ok ? ihp_pkg::ST_DN_L : ihp_pkg::ST_FINAL;
         end
         ihp_pkg::ST_DN_L: begin
            if (right_ok) begin
               state_in = ihp_pkg::ST_DN_R;
            end else begin
               state_in = child_less ? ihp_pkg::ST_DOWN : ihp_pkg::ST_FINAL;
            end
         end
         ihp_pkg::ST_DN_R: begin
            state_in = (right_less || cand_move_ff) ? ihp_pkg::ST_DOWN : ihp_pkg::ST_FINAL;
         end
         ihp_pkg::ST_FINAL: state_in = ihp_pkg::ST_DONE;
         ihp_pkg::ST_DONE: begin
            if (rsp_free) state_in = ihp_pkg::ST_IDLE;
         end
         default: state_in = ihp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in       = clr_ff;
      size_in      = size_ff;
      s_in         = s_ff;
      cv_in        = cv_ff;
      ck_in        = ck_ff;
      mode_in      = mode_ff;
      err_in       = err_ff;
      cand_val_in  = cand_val_ff;
      cand_key_in  = cand_key_ff;
      cand_move_in = cand_move_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      item_pop     = 1'b0;
      slot_wr_en   = 1'b0;
      slot_wr_addr = AW'(s_ff - SW'(1));
      slot_wr_data = {ck_ff, cv_ff};
      slot_rd_addr = '0;
      kp_wr_en     = 1'b0;
      kp_wr_addr   = ck_ff;
      kp_wr_data   = s_ff;
      kp_rd_addr   = item.key;
      unique case (state_ff)
         ihp_pkg::ST_CLEAR: begin
            kp_wr_en   = 1'b1;
            kp_wr_addr = clr_ff;
            kp_wr_data = '0;
            clr_in     = clr_ff + KAW'(1);
         end
         ihp_pkg::ST_IDLE: begin
            item_pop = item_valid;
            if (item_valid) begin
               cv_in   = item.value;
               ck_in   = item.key;
               mode_in = item.mode;
            end
         end
         ihp_pkg::ST_LOOK: begin
            err_in       = look_err;
            slot_rd_addr = AW'(kp_rd_data - SW'(1));
            if (look_err == ihp_pkg::ERR_NONE) begin
               if (mode_ff == ihp_pkg::MODE_PUSH) begin
                  size_in = size_ff + SW'(1);
                  s_in    = size_ff + SW'(1);
               end else begin
                  s_in = kp_rd_data;
               end
            end
         end
         ihp_pkg::ST_OLD: begin
         end
         ihp_pkg::ST_UP: begin
            slot_rd_addr = AW'(parent - SW'(1));
         end
         ihp_pkg::ST_UP_CMP: begin
            if (up_less) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = slot_rd_data;
               kp_wr_en     = 1'b1;
               kp_wr_addr   = rd_key;
               s_in         = parent;
            end
         end
         ihp_pkg::ST_DOWN: begin
            slot_rd_addr = AW'(left - (SW+1)'(1));
         end
         ihp_pkg::ST_DN_L: begin
            cand_move_in = child_less;
            cand_val_in  = child_less ? rd_val : cv_ff;
            cand_key_in  = rd_key;
            slot_rd_addr = AW'(right - (SW+1)'(1));
            if (!right_ok && child_less) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = slot_rd_data;
               kp_wr_en     = 1'b1;
               kp_wr_addr   = rd_key;
               s_in         = SW'(left);
            end
         end
         ihp_pkg::ST_DN_R: begin
            if (right_less) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = slot_rd_data;
               kp_wr_en     = 1'b1;
               kp_wr_addr   = rd_key;
               s_in         = SW'(right);
            end else if (cand_move_ff) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = {cand_key_ff, cand_val_ff};
               kp_wr_en     = 1'b1;
               kp_wr_addr   = cand_key_ff;
               s_in         = SW'(left);
            end
         end
         ihp_pkg::ST_FINAL: begin
            slot_wr_en = 1'b1;
            kp_wr_en   = 1'b1;
         end
         ihp_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.has_entries = (size_ff != '0);
               rsp_in.min_value   = (size_ff != '0) ? root_val_ff : '0;
               rsp_in.min_key     = (size_ff != '0) ? root_key_ff : '0;
               rsp_in.entry_count = ihp_pkg::COUNT_W'(size_ff);
               rsp_in.error       = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // shadow of slot 1
   always_comb begin
      root_val_in = root_val_ff;
      root_key_in = root_key_ff;
      if (slot_wr_en && slot_wr_addr == '0) begin
         root_val_in = slot_wr_data[VW-1:0];
         root_key_in = slot_wr_data[ihp_pkg::SLOT_W-1:VW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ihp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      cv_ff        <= cv_in;
      ck_ff        <= ck_in;
      mode_ff      <= mode_in;
      err_ff       <= err_in;
      cand_val_ff  <= cand_val_in;
      cand_key_ff  <= cand_key_in;
      cand_move_ff <= cand_move_in;
      root_val_ff  <= root_val_in;
      root_key_ff  <= root_key_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- rtl/indexed_min_heap_top.sv -----
`timescale 1ns / 1ps
// Indexed binary min-heap with change-key.
// req channel: one item per push (tuser 0) or value change (tuser 1) of a key.
// rsp channel: exactly one result item per request, in order: root value and
//   key, entry count, non-empty flag and an error code in tuser.
// A two-item queue takes requests while the heap sequencer is busy.
// A rejected item goes straight to its result. A push climbs level by level
//   until its parent is not larger or it reaches the root; a value change first
//   compares with the old value, then climbs or sifts down level by level.
// The sequencer handles one item at a time.
// Reset: the key-to-slot map is cleared after reset, one entry a cycle over all
//   1024 keys; requests queue but are not processed until it finishes.
// A stalled rsp holds its result; the sequencer waits before writing the next
//   result while up to two more requests are still accepted.
module indexed_min_heap_top #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // key[9:0], value[41:10], zero
   input  logic [0:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // min_value, min_key, entry_count, has_entries, zero
   output logic [1:0]  rsp_tuser    // error
);

   ihp_pkg::item_type   in_item, q_item;
   ihp_pkg::result_type result;
   logic                q_valid, q_pop;

   assign in_item.mode  = ihp_pkg::mode_type'(req_tuser[0]);
   assign in_item.key   = req_tdata[9:0];
   assign in_item.value = req_tdata[41:10];

   ihp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .out_valid(q_valid),
      .out_pop  (q_pop),
      .out_item (q_item)
   );

   ihp_back #(.CAPACITY(CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(q_valid),
      .item      (q_item),
      .item_pop  (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (result)
   );

   assign rsp_tdata = {2'b00, result.has_entries, result.entry_count,
                       result.min_key, result.min_value};
   assign rsp_tuser = result.error;

endmodule

// ----- rtl/ihp_checker.sv -----
`timescale 1ns / 1ps
`include "indexed_min_heap_top_assert.svh"
module ihp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   `IHP_ASSERT_RST(a_no_rsp_after_reset, reset |=> !rsp_tvalid)
   `IHP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `IHP_ASSERT(a_flag_count, rsp_tvalid |-> rsp_tdata[53] == (rsp_tdata[52:42] != 11'd0))
   `IHP_ASSERT(a_empty_zero, rsp_tvalid && !rsp_tdata[53] |-> rsp_tdata[41:0] == 42'd0)

endmodule

bind indexed_min_heap_top ihp_checker u_ihp_checker (.*);

// ----- sim/indexed_min_heap_top_tb.sv -----
`timescale 1ns / 1ps
module indexed_min_heap_top_tb;

   localparam int CAP = 1024;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   indexed_min_heap_top #(.CAPACITY(CAP)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // heap shadow
   logic signed [31:0] heap_val [1:CAP];
   logic [9:0]         heap_key [1:CAP];
   int                 key_slot [0:ihp_pkg::KEY_SPACE-1];
   int                 heap_count;

   ihp_pkg::result_type expected_results[$];
   int  failures = 0;
   int  idle_cycles = 0;
   bit  stall_mode = 0;

   function automatic void swap_entries(int a, int b);
      logic signed [31:0] v;
      logic [9:0] k;
      v = heap_val[a]; k = heap_key[a];
      heap_val[a] = heap_val[b]; heap_key[a] = heap_key[b];
      heap_val[b] = v; heap_key[b] = k;
      key_slot[heap_key[a]] = a;
      key_slot[heap_key[b]] = b;
   endfunction

   function automatic void bubble_up(int s);
      while (s > 1 && heap_val[s] < heap_val[s/2]) begin
         swap_entries(s, s/2);
         s = s/2;
      end
   endfunction

   function automatic void bubble_down(int s);
      int best;
      forever begin
         best = s;
         if (2*s <= heap_count && heap_val[2*s] < heap_val[best]) best = 2*s;
         if (2*s+1 <= heap_count && heap_val[2*s+1] < heap_val[best]) best = 2*s+1;
         if (best == s) return;
         swap_entries(s, best);
         s = best;
      end
   endfunction

   function automatic ihp_pkg::result_type heap_apply(ihp_pkg::mode_type m,
                                                      logic [9:0] k,
                                                      logic signed [31:0] v);
      ihp_pkg::result_type r;
      int s;
      r.error = ihp_pkg::ERR_NONE;
      if (m == ihp_pkg::MODE_PUSH) begin
         if (heap_count >= CAP) r.error = ihp_pkg::ERR_FULL;
         else if (key_slot[k] != 0) r.error = ihp_pkg::ERR_PRESENT;
         else begin
            heap_count++;
            heap_val[heap_count] = v;
            heap_key[heap_count] = k;
            key_slot[k] = heap_count;
            bubble_up(heap_count);
         end
      end else begin
         s = key_slot[k];
         if (s == 0 || s > heap_count) r.error = ihp_pkg::ERR_ABSENT;
         else if (v > heap_val[s]) begin
            heap_val[s] = v; bubble_down(s);
         end else begin
            heap_val[s] = v; bubble_up(s);
         end
      end
      r.has_entries = heap_count > 0;
      r.min_value = heap_count > 0 ? heap_val[1] : '0;
      r.min_key = heap_count > 0 ? heap_key[1] : '0;
      r.entry_count = heap_count[10:0];
      return r;
   endfunction

   task automatic send_item(ihp_pkg::mode_type m, logic [9:0] k, logic [31:0] v);
      ihp_pkg::result_type r;
      r = heap_apply(m, k, v);
      expected_results.push_back(r);
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {6'd0, v, k};
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // receiver stall pattern: phases of always ready and random stalls
   always @(posedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      rsp_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
   end

   always @(posedge clock) begin
      ihp_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h/%h",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.min_value)
               begin $display("%0t min_value: expected %h actual %h", $time,
                  want.min_value, rsp_tdata[31:0]); failures++; end
            if (rsp_tdata[41:32] !== want.min_key)
               begin $display("%0t min_key: expected %h actual %h", $time,
                  want.min_key, rsp_tdata[41:32]); failures++; end
            if (rsp_tdata[52:42] !== want.entry_count)
               begin $display("%0t entry_count: expected %0d actual %0d", $time,
                  want.entry_count, rsp_tdata[52:42]); failures++; end
            if (rsp_tdata[53] !== want.has_entries)
               begin $display("%0t has_entries: expected %b actual %b", $time,
                  want.has_entries, rsp_tdata[53]); failures++; end
            if (rsp_tuser !== want.error)
               begin $display("%0t error: expected %0d actual %0d", $time,
                  want.error, rsp_tuser); failures++; end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [9:0] pick_free_key();
      logic [9:0] k;
      do k = $urandom_range(0, ihp_pkg::KEY_SPACE-1); while (key_slot[k] != 0);
      return k;
   endfunction

   function automatic logic [9:0] pick_held_key();
      return heap_key[$urandom_range(1, heap_count)];
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed;
      send_item(ihp_pkg::MODE_MODIFY, 10'd5, 32'd1);        // absent key on empty heap
      send_item(ihp_pkg::MODE_PUSH, 10'd0, 32'h7FFF_FFFF);
      send_item(ihp_pkg::MODE_PUSH, 10'd1023, 32'h8000_0000);
      send_item(ihp_pkg::MODE_PUSH, 10'd1023, 32'd3);       // key already held
      send_item(ihp_pkg::MODE_PUSH, 10'h155, 32'd0);
      send_item(ihp_pkg::MODE_PUSH, 10'h2AA, 32'd0);        // tie
      send_item(ihp_pkg::MODE_PUSH, 10'd7, 32'hFFFF_FFFF);
      send_item(ihp_pkg::MODE_MODIFY, 10'd1023, 32'h8000_0000); // same value
      send_item(ihp_pkg::MODE_MODIFY, 10'd1023, 32'h7FFF_FFFF); // sink
      send_item(ihp_pkg::MODE_MODIFY, 10'd0, 32'h8000_0000);    // rise to root
      send_item(ihp_pkg::MODE_MODIFY, 10'd0, 32'd0);            // tie on sinking
      send_item(ihp_pkg::MODE_MODIFY, 10'd9, 32'd0);            // absent
      send_item(ihp_pkg::MODE_PUSH, 10'd9, 32'h5555_5555);
      send_item(ihp_pkg::MODE_PUSH, 10'd10, 32'hAAAA_AAAA);
      drain();
   endtask

   task automatic test_fill_to_capacity;
      while (heap_count < CAP) begin
         if ($urandom_range(0, 7) == 0)
            send_item(ihp_pkg::MODE_MODIFY, pick_held_key(), rand_value());
         else send_item(ihp_pkg::MODE_PUSH, pick_free_key(), rand_value());
      end
      send_item(ihp_pkg::MODE_PUSH, 10'd3, 32'd1);     // full, held key
      send_item(ihp_pkg::MODE_MODIFY, pick_held_key(), 32'h8000_0000);
      send_item(ihp_pkg::MODE_MODIFY, pick_held_key(), 32'h7FFF_FFFF);
      drain();
   endtask

   task automatic test_random(int n);
      logic [9:0] k;
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, ihp_pkg::KEY_SPACE-1);
            send_item(ihp_pkg::mode_type'($urandom_range(0, 1)), k, $urandom);
         end else if (heap_count == 0 || $urandom_range(0, 1) == 0)
            send_item(ihp_pkg::MODE_PUSH, pick_free_key(), rand_value());
         else send_item(ihp_pkg::MODE_MODIFY, pick_held_key(), rand_value());
      end
      drain();
   endtask

   initial begin
      heap_count = 0;
      for (int i = 0; i < ihp_pkg::KEY_SPACE; i++) key_slot[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(260);
      test_fill_to_capacity();
      if (failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
